// ===== sv/bptc_pkg.sv =====
// Shared constants, register codes and arithmetic helpers for the
// barometric pressure/temperature compensation block. No dependencies.
package bptc_pkg;

  typedef enum logic [1:0] {
    REG_TEMP_CALIB  = 2'd0,
    REG_PRESS_LOW   = 2'd1,
    REG_PRESS_HIGH  = 2'd2,
    REG_PRESS_LAST  = 2'd3
  } cfg_reg_e;

  localparam int unsigned CFG_W      = 64;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned FRONT_ST   = 11;
  localparam int unsigned BACK_ST    = 6;
  localparam int unsigned PIPE_LAT   = FRONT_ST + DIV_STEPS + BACK_ST;

  localparam logic [20:0] FULL_SCALE = 21'd1048576;
  localparam logic [32:0] T_OFFSET   = 33'd128000;
  localparam logic [15:0] P_SCALE    = 16'd3125;
  localparam logic [31:0] T_ROUND    = 32'd128;
  localparam logic [63:0] P1_BIAS    = 64'h0000_8000_0000_0000;

  function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
    return 64'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  // low 64 bits of a times unsigned 16-bit b
  function automatic logic [63:0] mul_u16(logic [63:0] a, logic [15:0] b);
    logic [79:0] pr;
    pr = {16'd0, a} * {64'd0, b};
    return pr[63:0];
  endfunction

  // low 64 bits of a times signed 16-bit b
  function automatic logic [63:0] mul_s16(logic [63:0] a, logic [15:0] b);
    logic [63:0] lo;
    lo = mul_u16(a, b);
    return b[15] ? (lo - {a[47:0], 16'd0}) : lo;
  endfunction

endpackage

// ===== sv/bptc_if.sv =====
// Request and result channels of the compensation block.
// Depends on nothing.
interface bptc_req_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_pressure;
  logic [19:0] raw_temperature;
  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bptc_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_centi_deg;
  logic        [31:0] pressure_scaled;
  logic               pressure_invalid;
  modport source (output valid, temp_centi_deg, pressure_scaled, pressure_invalid,
                  input ready);
  modport sink   (input valid, temp_centi_deg, pressure_scaled, pressure_invalid,
                  output ready);
endinterface

// ===== sv/baro_pressure_temp_compensation.sv =====
// Top level: pipelined integer temperature and pressure compensation.
// Depends on bptc_pkg and the channel interfaces in bptc_if.sv.

// One request enters per cycle unless a stall on the result side holds the
// whole pipeline; results leave one per cycle while the result side takes them.
// The pipeline consists of the signed 64-bit division, done one quotient bit per
// stage over 64 stages, plus eleven stages of temperature and pressure terms
// before it and six of correction after it. Calibration registers are read
// directly by the stages that use them; write them only when no request is in
// flight. A zero divisor term gives pressure 0 with the invalid flag set.
module baro_pressure_temp_compensation
  import bptc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  bptc_req_if.sink         req_i,
  bptc_res_if.source       res_o
);

  logic [47:0] temp_calib_q;
  logic [63:0] press_low_q, press_high_q;
  logic [15:0] press_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      press_low_q  <= '0;
      press_high_q <= '0;
      press_last_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TEMP_CALIB: temp_calib_q <= cfg_wdata_i[47:0];
        REG_PRESS_LOW:  press_low_q  <= cfg_wdata_i;
        REG_PRESS_HIGH: press_high_q <= cfg_wdata_i;
        REG_PRESS_LAST: press_last_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = temp_calib_q[15:0];
  assign t2 = temp_calib_q[31:16];
  assign t3 = temp_calib_q[47:32];
  assign p1 = press_low_q[15:0];
  assign p2 = press_low_q[31:16];
  assign p3 = press_low_q[47:32];
  assign p4 = press_low_q[63:48];
  assign p5 = press_high_q[15:0];
  assign p6 = press_high_q[31:16];
  assign p7 = press_high_q[47:32];
  assign p8 = press_high_q[63:48];
  assign p9 = press_last_q;

  logic adv;
  logic [PIPE_LAT-1:0] vld_q;
  assign adv         = !vld_q[PIPE_LAT-1] || res_o.ready;
  assign req_i.ready = adv;
  assign res_o.valid = vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], req_i.valid};
    end
  end

  // front stages
  logic [17:0] s1_d1_q;
  logic [16:0] s1_d2_q;
  logic [19:0] s1_ap_q, s2_ap_q, s3_ap_q, s4_ap_q, s5_ap_q, s6_ap_q, s7_ap_q, s8_ap_q;
  logic [31:0] s2_m1_q, s2_sq_q, s3_v1t_q, s3_m3_q, s4_tf_q;
  logic [15:0] s5_tout_q, s6_tout_q, s7_tout_q, s8_tout_q, s9_tout_q, s10_tout_q;
  logic [32:0] s5_v1_q;
  logic [63:0] s6_vsq_q, s6_vp5_q, s6_vp2_q;
  logic [63:0] s7_x6_q, s7_x3_q, s7_vp5_q, s7_vp2_q;
  logic [63:0] s8_v2_q, s8_v1b_q;
  logic [63:0] s9_y_q, s9_npre_q, s10_v1c_q, s10_num_q;

  logic signed [33:0] m1_w, sq_w;
  logic signed [35:0] m3_w;
  logic        [31:0] a2_w, t5_w;
  logic signed [31:0] tc_w;
  logic        [15:0] tout_w;
  logic signed [65:0] vsq_w;
  logic signed [48:0] vp5_w, vp2_w;
  logic        [20:0] pdiff_w;

  always_comb begin
    m1_w  = $signed(s1_d1_q) * $signed(t2);
    sq_w  = $signed(s1_d2_q) * $signed(s1_d2_q);
    a2_w  = asr32(s2_sq_q, 12);
    m3_w  = $signed(a2_w[19:0]) * $signed(t3);
    t5_w  = (s4_tf_q << 2) + s4_tf_q + T_ROUND;
    tc_w  = $signed(asr32(t5_w, 8));
    if (tc_w < -32'sd32768) begin
      tout_w = 16'h8000;
    end else if (tc_w > 32'sd32767) begin
      tout_w = 16'h7FFF;
    end else begin
      tout_w = tc_w[15:0];
    end
    vsq_w   = $signed(s5_v1_q) * $signed(s5_v1_q);
    vp5_w   = $signed(s5_v1_q) * $signed(p5);
    vp2_w   = $signed(s5_v1_q) * $signed(p2);
    pdiff_w = FULL_SCALE - {1'b0, s8_ap_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_d1_q    <= {1'b0, req_i.raw_temperature[19:3]} - {1'b0, t1, 1'b0};
      s1_d2_q    <= {1'b0, req_i.raw_temperature[19:4]} - {1'b0, t1};
      s1_ap_q    <= req_i.raw_pressure;
      s2_m1_q    <= m1_w[31:0];
      s2_sq_q    <= sq_w[31:0];
      s2_ap_q    <= s1_ap_q;
      s3_v1t_q   <= asr32(s2_m1_q, 11);
      s3_m3_q    <= m3_w[31:0];
      s3_ap_q    <= s2_ap_q;
      s4_tf_q    <= s3_v1t_q + asr32(s3_m3_q, 14);
      s4_ap_q    <= s3_ap_q;
      s5_tout_q  <= tout_w;
      s5_v1_q    <= {s4_tf_q[31], s4_tf_q} - T_OFFSET;
      s5_ap_q    <= s4_ap_q;
      s6_vsq_q   <= vsq_w[63:0];
      s6_vp5_q   <= {{15{vp5_w[48]}}, vp5_w};
      s6_vp2_q   <= {{15{vp2_w[48]}}, vp2_w};
      s6_tout_q  <= s5_tout_q;
      s6_ap_q    <= s5_ap_q;
      s7_x6_q    <= mul_s16(s6_vsq_q, p6);
      s7_x3_q    <= mul_s16(s6_vsq_q, p3);
      s7_vp5_q   <= s6_vp5_q << 17;
      s7_vp2_q   <= s6_vp2_q << 12;
      s7_tout_q  <= s6_tout_q;
      s7_ap_q    <= s6_ap_q;
      s8_v2_q    <= s7_x6_q + s7_vp5_q + (sx16(p4) << 35);
      s8_v1b_q   <= asr64(s7_x3_q, 8) + s7_vp2_q;
      s8_tout_q  <= s7_tout_q;
      s8_ap_q    <= s7_ap_q;
      s9_y_q     <= mul_u16(P1_BIAS + s8_v1b_q, p1);
      s9_npre_q  <= ({43'd0, pdiff_w} << 31) - s8_v2_q;
      s9_tout_q  <= s8_tout_q;
      s10_v1c_q  <= asr64(s9_y_q, 33);
      s10_num_q  <= mul_u16(s9_npre_q, P_SCALE);
      s10_tout_q <= s9_tout_q;
    end
  end

  // divider: stage 0 holds magnitudes, each later stage resolves one quotient bit
  logic [63:0] dv_rem_q [DIV_STEPS+1];
  logic [63:0] dv_nq_q  [DIV_STEPS+1];
  logic [63:0] dv_den_q [DIV_STEPS+1];
  logic        dv_neg_q [DIV_STEPS+1];
  logic        dv_inv_q [DIV_STEPS+1];
  logic [15:0] dv_tout_q[DIV_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_rem_q[0]  <= '0;
      dv_nq_q[0]   <= s10_num_q[63] ? (64'd0 - s10_num_q) : s10_num_q;
      dv_den_q[0]  <= s10_v1c_q[63] ? (64'd0 - s10_v1c_q) : s10_v1c_q;
      dv_neg_q[0]  <= s10_num_q[63] ^ s10_v1c_q[63];
      dv_inv_q[0]  <= (s10_v1c_q == '0);
      dv_tout_q[0] <= s10_tout_q;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [64:0] r_w, diff_w;
    logic        ge_w;
    always_comb begin
      r_w    = {dv_rem_q[k], dv_nq_q[k][63]};
      diff_w = r_w - {1'b0, dv_den_q[k]};
      ge_w   = !diff_w[64];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[k+1]  <= ge_w ? diff_w[63:0] : r_w[63:0];
        dv_nq_q[k+1]   <= {dv_nq_q[k][62:0], ge_w};
        dv_den_q[k+1]  <= dv_den_q[k];
        dv_neg_q[k+1]  <= dv_neg_q[k];
        dv_inv_q[k+1]  <= dv_inv_q[k];
        dv_tout_q[k+1] <= dv_tout_q[k];
      end
    end
  end

  // back stages
  logic [63:0] b1_p_q, b2_p_q, b3_p_q, b4_p_q;
  logic [63:0] b2_q13_q, b2_pa_q, b2_pb_q;
  logic [63:0] b3_lo_q, b3_bs_q, b4_bs_q, b4_at_q, b5_s_q;
  logic [31:0] b3_c1_q, b3_c2_q;
  logic        b1_inv_q, b2_inv_q, b3_inv_q, b4_inv_q, b5_inv_q;
  logic [15:0] b1_tout_q, b2_tout_q, b3_tout_q, b4_tout_q, b5_tout_q;
  logic [63:0] c1_w, c2_w, fin_w;

  always_comb begin
    c1_w  = b2_pa_q[31:0] * b2_q13_q[63:32];
    c2_w  = b2_pa_q[63:32] * b2_q13_q[31:0];
    fin_w = asr64(b5_s_q, 8) + (sx16(p7) << 4);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_p_q    <= dv_neg_q[DIV_STEPS] ? (64'd0 - dv_nq_q[DIV_STEPS]) : dv_nq_q[DIV_STEPS];
      b1_inv_q  <= dv_inv_q[DIV_STEPS];
      b1_tout_q <= dv_tout_q[DIV_STEPS];
      b2_q13_q  <= asr64(b1_p_q, 13);
      b2_pa_q   <= mul_s16(asr64(b1_p_q, 13), p9);
      b2_pb_q   <= mul_s16(b1_p_q, p8);
      b2_p_q    <= b1_p_q;
      b2_inv_q  <= b1_inv_q;
      b2_tout_q <= b1_tout_q;
      b3_lo_q   <= b2_pa_q[31:0] * b2_q13_q[31:0];
      b3_c1_q   <= c1_w[31:0];
      b3_c2_q   <= c2_w[31:0];
      b3_bs_q   <= asr64(b2_pb_q, 19);
      b3_p_q    <= b2_p_q;
      b3_inv_q  <= b2_inv_q;
      b3_tout_q <= b2_tout_q;
      b4_at_q   <= b3_lo_q + {b3_c1_q + b3_c2_q, 32'd0};
      b4_bs_q   <= b3_bs_q;
      b4_p_q    <= b3_p_q;
      b4_inv_q  <= b3_inv_q;
      b4_tout_q <= b3_tout_q;
      b5_s_q    <= b4_p_q + asr64(b4_at_q, 25) + b4_bs_q;
      b5_inv_q  <= b4_inv_q;
      b5_tout_q <= b4_tout_q;
      res_o.pressure_scaled  <= b5_inv_q ? 32'd0 : fin_w[31:0];
      res_o.pressure_invalid <= b5_inv_q;
      res_o.temp_centi_deg   <= b5_tout_q;
    end
  end

endmodule

// ===== sv/bptc_chk.sv =====
// Port-level checks for the compensation block, bound to its top level.
// Depends on baro_pressure_temp_compensation's ports only.
module bptc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] res_temp,
  input logic [31:0] res_press,
  input logic        res_inval
);

  ap_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready == (!res_valid || res_ready))
    else $error("request ready does not follow result side");

  ap_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_inval |-> res_press == 32'd0)
    else $error("invalid pressure is not zero");

  ap_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_temp) && $stable(res_press)
      && $stable(res_inval))
    else $error("stalled result changed");

  ap_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind baro_pressure_temp_compensation bptc_chk u_bptc_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .req_ready (req_i.ready),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .res_temp  (res_o.temp_centi_deg),
  .res_press (res_o.pressure_scaled),
  .res_inval (res_o.pressure_invalid)
);

// ===== verif/bptc_checker.sv =====
// Checker for the compensation block: watches the configuration port and both
// channels, predicts each result and compares it. Depends on bptc_pkg, bptc_if.
`timescale 1ns / 100ps
module bptc_checker
  import bptc_pkg::*;
(
  input  logic             clk_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  bptc_req_if              req,
  bptc_res_if              res,
  output int               errors_o,
  output int               pending_o,
  output int               requests_o,
  output int               invalid_seen_o
);

  typedef struct packed {
    logic signed [15:0] temp;
    logic [31:0]        press;
    logic               inval;
  } comp_res_t;

  logic [47:0] temp_cal   = '0;
  logic [63:0] press_lo   = '0;
  logic [63:0] press_hi   = '0;
  logic [15:0] press_last = '0;
  int          err_cnt    = 0;
  int          req_cnt    = 0;
  int          inval_cnt  = 0;
  comp_res_t   comp_q[$];

  assign errors_o       = err_cnt;
  assign requests_o     = req_cnt;
  assign invalid_seen_o = inval_cnt;
  assign pending_o      = comp_q.size();

  function automatic logic [31:0] sra32(logic [31:0] x, int n);
    logic [31:0] r;
    r = x;
    for (int i = 0; i < n; i++) r = {r[31], r[31:1]};
    return r;
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] x, int n);
    logic [63:0] r;
    r = x;
    for (int i = 0; i < n; i++) r = {r[63], r[63:1]};
    return r;
  endfunction

  function automatic logic [63:0] sext16(logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  function automatic comp_res_t compensate(logic [19:0] rp, logic [19:0] rt);
    logic [31:0] t1, t2, t3, d1, d2, fine, tc;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] a, b, num, mn, md, q, pp, sq, c, d;
    comp_res_t   r;
    t1 = {16'd0, temp_cal[15:0]};
    t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
    t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
    p1 = {48'd0, press_lo[15:0]};
    p2 = sext16(press_lo[31:16]);
    p3 = sext16(press_lo[47:32]);
    p4 = sext16(press_lo[63:48]);
    p5 = sext16(press_hi[15:0]);
    p6 = sext16(press_hi[31:16]);
    p7 = sext16(press_hi[47:32]);
    p8 = sext16(press_hi[63:48]);
    p9 = sext16(press_last);
    d1 = {15'd0, rt[19:3]} - (t1 << 1);
    d2 = {16'd0, rt[19:4]} - t1;
    fine = sra32(d1 * t2, 11) + sra32(sra32(d2 * d2, 12) * t3, 14);
    tc = sra32(fine * 32'd5 + 32'd128, 8);
    if ($signed(tc) < -32768) r.temp = 16'sh8000;
    else if ($signed(tc) > 32767) r.temp = 16'sh7fff;
    else r.temp = tc[15:0];
    a = {{32{fine[31]}}, fine} - 64'd128000;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = sra64(a * a * p3, 8) + ((a * p2) << 12);
    a = sra64(((64'd1 << 47) + a) * p1, 33);
    if (a == 64'd0) begin
      r.press = '0;
      r.inval = 1'b1;
    end else begin
      pp  = 64'd1048576 - {44'd0, rp};
      num = ((pp << 31) - b) * 64'd3125;
      mn  = num[63] ? -num : num;
      md  = a[63] ? -a : a;
      q   = mn / md;
      pp  = (num[63] != a[63]) ? -q : q;
      sq  = sra64(pp, 13);
      c   = sra64(p9 * sq * sq, 25);
      d   = sra64(p8 * pp, 19);
      pp  = sra64(pp + c + d, 8) + (p7 << 4);
      r.press = pp[31:0];
      r.inval = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    comp_res_t exp_r;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEMP_CALIB: temp_cal   = cfg_wdata_i[47:0];
        REG_PRESS_LOW:  press_lo   = cfg_wdata_i;
        REG_PRESS_HIGH: press_hi   = cfg_wdata_i;
        REG_PRESS_LAST: press_last = cfg_wdata_i[15:0];
        default: ;
      endcase
    end
    if (req.valid && req.ready) begin
      comp_q.push_back(compensate(req.raw_pressure, req.raw_temperature));
      req_cnt++;
    end
    if (res.valid && res.ready) begin
      if (comp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("result with no request pending: t=%0d p=%h inv=%b",
                                    res.temp_centi_deg, res.pressure_scaled,
                                    res.pressure_invalid);
      end else begin
        exp_r = comp_q.pop_front();
        if (exp_r.inval) inval_cnt++;
        if (res.temp_centi_deg !== exp_r.temp || res.pressure_scaled !== exp_r.press ||
            res.pressure_invalid !== exp_r.inval) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp t=%0d p=%h inv=%b, got t=%0d p=%h inv=%b",
                     exp_r.temp, exp_r.press, exp_r.inval, res.temp_centi_deg,
                     res.pressure_scaled, res.pressure_invalid);
        end
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the compensation testbench: clock, reset, calibration writes,
// request stimulus and result back-pressure. Depends on bptc_pkg, bptc_if, bptc_checker.
`timescale 1ns / 100ps
module testbench;
  import bptc_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  int               errors, pending, requests, invalid_seen;
  int               stall_cnt = 0;
  bit               quiet;
  bit               hold_req, hold_done;

  bptc_req_if req();
  bptc_res_if res();

  baro_pressure_temp_compensation dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .req_i(req), .res_o(res)
  );

  bptc_checker chk (
    .clk_i, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .req(req), .res(res),
    .errors_o(errors), .pending_o(pending), .requests_o(requests),
    .invalid_seen_o(invalid_seen)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (res.valid && res.ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= 4000) begin
      $display("stalled with %0d results outstanding", pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int n;
    res.ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        res.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_done = 1'b1;
        res.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 13);
        res.ready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(logic [19:0] rp, logic [19:0] rt, bit gaps);
    int n;
    if (gaps && !quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 13);
      req.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    req.valid           <= 1'b1;
    req.raw_pressure    <= rp;
    req.raw_temperature <= rt;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (PIPE_LAT + 8) @(negedge clk_i);
  endtask

  task automatic write_cal(cfg_reg_e idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_cal(logic [47:0] tc, logic [63:0] lo, logic [63:0] hi,
                          logic [15:0] last);
    drain();
    write_cal(REG_TEMP_CALIB, {16'd0, tc});
    write_cal(REG_PRESS_LOW, lo);
    write_cal(REG_PRESS_HIGH, hi);
    write_cal(REG_PRESS_LAST, {48'd0, last});
  endtask

  function automatic logic [19:0] rand20();
    case ($urandom_range(0, 5))
      0:       return 20'h0;
      1:       return 20'hfffff;
      2:       return 20'(370000 + $urandom_range(0, 300000));
      default: return 20'($urandom);
    endcase
  endfunction

  logic [47:0] typ_t;
  logic [63:0] typ_lo, typ_hi;

  initial begin
    logic [19:0] ext[5];
    logic [63:0] r64;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_TEMP_CALIB;
    cfg_wdata_i         = '0;
    req.valid           = 1'b0;
    req.raw_pressure    = '0;
    req.raw_temperature = '0;
    quiet               = 1'b0;
    hold_req            = 1'b0;
    ext     = '{20'h0, 20'hfffff, 20'h80000, 20'h7ffff, 20'h55555};
    typ_t   = {16'hfc18, 16'd26435, 16'd27504};
    typ_lo  = {16'd2855, 16'd3024, 16'hd843, 16'd36477};
    typ_hi  = {16'hc6f8, 16'd15500, 16'hfff9, 16'd140};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset calibration: divisor term zero
    for (int i = 0; i < 5; i++) send_sample(ext[i], ext[4 - i], 1'b0);

    load_cal(typ_t, typ_lo, typ_hi, 16'd6000);
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 2; j++) send_sample(ext[i], ext[(i + 2 * j + 1) % 5], 1'b0);
    send_sample(20'd415148, 20'd519888, 1'b0);

    load_cal('1, '1, '1, 16'hffff);
    for (int i = 0; i < 5; i++) send_sample(ext[i], ext[i], 1'b0);
    load_cal({16'h8000, 16'h8000, 16'hffff}, {{3{16'h8000}}, 16'hffff},
             {4{16'h7fff}}, 16'h8000);
    for (int i = 0; i < 5; i++) send_sample(ext[4 - i], ext[i], 1'b0);

    for (int k = 0; k < 6; k++) begin
      if (k == 0) load_cal(typ_t, typ_lo, typ_hi, 16'd6000);
      else if (k == 1) load_cal(48'($urandom) | {32'($urandom), 16'd0}, 64'h0, '1, 16'h7fff);
      else begin
        r64 = {$urandom, $urandom};
        if ($urandom_range(0, 1)) r64 = {r64[63:16], typ_lo[15:0] ^ 16'($urandom_range(0, 255))};
        load_cal({16'($urandom), 32'($urandom)}, r64, {$urandom, $urandom}, 16'($urandom));
      end
      if (k == 2) begin
        hold_req = 1'b1;
        while (!hold_done) send_sample(rand20(), rand20(), 1'b0);
      end
      if (k == 5) quiet = 1'b1;
      for (int i = 0; i < 300; i++) begin
        send_sample(rand20(), rand20(), 1'b1);
        if (i == 150 && k == 3) begin
          req.valid <= 1'b0;
          while (pending != 0) @(negedge clk_i);
        end
      end
    end

    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (PIPE_LAT + 8) @(negedge clk_i);
    $display("%0d samples over ten calibration sets, %0d with zero divisor",
             requests, invalid_seen);
    $display("long result stall and full drain pause exercised, %0d errors", errors);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
